// ----- hw/rtl/qrbk_pkg.sv -----
// qrbk_pkg: shared types and fixed-point helpers for the quaternion kinematics unit
// no dependencies; used by qrbk_rot_entries and quaternion_rigid_body_kinematics_unit
package qrbk_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] acc_t;

  localparam int NUM_DQ_PROD  = 12;
  localparam int NUM_Q_PROD   = 9;
  localparam int NUM_ROT      = 9;
  localparam int NUM_VEL      = 3;
  localparam int NUM_DQ       = 4;

  // quaternion product slots
  localparam int QP_XX = 0;
  localparam int QP_YY = 1;
  localparam int QP_ZZ = 2;
  localparam int QP_XY = 3;
  localparam int QP_ZW = 4;
  localparam int QP_XZ = 5;
  localparam int QP_YW = 6;
  localparam int QP_YZ = 7;
  localparam int QP_XW = 8;

  // one in Q6.60, unit of the doubled quaternion products
  localparam acc_t ONE_Q60 = acc_t'(66'sd1 <<< 60);

  // signed 32x32 product
  function automatic prod_t mul(input word_t a, input word_t b);
    mul = prod_t'(a) * prod_t'(b);
  endfunction

  function automatic acc_t ext(input prod_t t);
    ext = {{2{t[63]}}, t};
  endfunction

  function automatic acc_t dbl(input prod_t t);
    dbl = {t[63], t, 1'b0};
  endfunction

  function automatic word_t sat37(input logic signed [36:0] q);
    logic signed [36:0] hi_lim;
    logic signed [36:0] lo_lim;
    hi_lim = 37'sh0_7FFF_FFFF;
    lo_lim = -37'sh0_8000_0000;
    if (q > hi_lim) begin
      sat37 = 32'sh7FFF_FFFF;
    end else if (q < lo_lim) begin
      sat37 = -32'sh8000_0000;
    end else begin
      sat37 = q[31:0];
    end
  endfunction

  // round half up of s / 2^31, then saturate
  function automatic word_t round_sat31(input acc_t s);
    logic signed [66:0] t;
    t = {s[65], s} + (67'sd1 <<< 30);
    round_sat31 = sat37({t[66], t[66:31]});
  endfunction

  // round half up of s / 2^30, then saturate
  function automatic word_t round_sat30(input acc_t s);
    logic signed [66:0] t;
    t = {s[65], s} + (67'sd1 <<< 29);
    round_sat30 = sat37(t[66:30]);
  endfunction

endpackage

// ----- hw/rtl/quaternion_rigid_body_kinematics_unit.sv -----
// quaternion_rigid_body_kinematics_unit: quaternion derivative and world position rate
// depends on qrbk_pkg and qrbk_rot_entries
// Four-stage pipeline, one word per clock while out_ready is high; out_valid
// rises when the word reaches stage 4. Stage 1 forms the 21 quaternion and rate
// products (32x32), stage 2 sums and rounds them into the quaternion derivative
// and the nine Q2.30 rotation entries, stage 3 forms the nine entry-by-velocity
// products, stage 4 sums, rounds and saturates into the output register. Each
// stage advances when it is empty or the next one moves, so bubbles fill while
// a result waits and a stall neither drops nor repeats a word. The quaternion
// is used as given, without normalization; all results round half up and
// saturate to 32 bits.
module quaternion_rigid_body_kinematics_unit
  import qrbk_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  word_t quat_w,
  input  word_t quat_x,
  input  word_t quat_y,
  input  word_t quat_z,
  input  word_t vel_u,
  input  word_t vel_v,
  input  word_t vel_w,
  input  word_t rate_p,
  input  word_t rate_q,
  input  word_t rate_r,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t dquat_w,
  output word_t dquat_x,
  output word_t dquat_y,
  output word_t dquat_z,
  output word_t dpos_x,
  output word_t dpos_y,
  output word_t dpos_z
);

  logic  v1, v2, v3, v4;
  logic  en1, en2, en3, en4;

  prod_t dqp   [NUM_DQ_PROD];
  prod_t qp    [NUM_Q_PROD];
  word_t vel1  [NUM_VEL];
  word_t dq2   [NUM_DQ];
  word_t rot2  [NUM_ROT];
  word_t vel2  [NUM_VEL];
  word_t dq3   [NUM_DQ];
  prod_t mp    [NUM_ROT];
  word_t res4  [NUM_DQ + NUM_VEL];

  prod_t dqp_next [NUM_DQ_PROD];
  prod_t qp_next  [NUM_Q_PROD];
  word_t dq_next  [NUM_DQ];
  word_t rot_next [NUM_ROT];
  prod_t mp_next  [NUM_ROT];
  word_t res_next [NUM_DQ + NUM_VEL];

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1 products
  always_comb begin
    dqp_next[0]  = mul(rate_p, quat_x);
    dqp_next[1]  = mul(rate_q, quat_y);
    dqp_next[2]  = mul(rate_r, quat_z);
    dqp_next[3]  = mul(rate_p, quat_w);
    dqp_next[4]  = mul(rate_r, quat_y);
    dqp_next[5]  = mul(rate_q, quat_z);
    dqp_next[6]  = mul(rate_q, quat_w);
    dqp_next[7]  = mul(rate_r, quat_x);
    dqp_next[8]  = mul(rate_p, quat_z);
    dqp_next[9]  = mul(rate_r, quat_w);
    dqp_next[10] = mul(rate_q, quat_x);
    dqp_next[11] = mul(rate_p, quat_y);
    qp_next[QP_XX] = mul(quat_x, quat_x);
    qp_next[QP_YY] = mul(quat_y, quat_y);
    qp_next[QP_ZZ] = mul(quat_z, quat_z);
    qp_next[QP_XY] = mul(quat_x, quat_y);
    qp_next[QP_ZW] = mul(quat_z, quat_w);
    qp_next[QP_XZ] = mul(quat_x, quat_z);
    qp_next[QP_YW] = mul(quat_y, quat_w);
    qp_next[QP_YZ] = mul(quat_y, quat_z);
    qp_next[QP_XW] = mul(quat_x, quat_w);
  end

  // stage 2 sums of the derivative
  always_comb begin
    dq_next[0] = round_sat31(-ext(dqp[0]) - ext(dqp[1]) - ext(dqp[2]));
    dq_next[1] = round_sat31(ext(dqp[3]) + ext(dqp[4]) - ext(dqp[5]));
    dq_next[2] = round_sat31(ext(dqp[6]) - ext(dqp[7]) + ext(dqp[8]));
    dq_next[3] = round_sat31(ext(dqp[9]) + ext(dqp[10]) - ext(dqp[11]));
  end

  qrbk_rot_entries u_rot (
    .qp (qp),
    .m  (rot_next)
  );

  // stage 3 products, stage 4 row sums
  always_comb begin
    for (int i = 0; i < NUM_ROT; i++) begin
      mp_next[i] = mul(rot2[i], vel2[i % NUM_VEL]);
    end
    for (int i = 0; i < NUM_DQ; i++) begin
      res_next[i] = dq3[i];
    end
    for (int i = 0; i < NUM_VEL; i++) begin
      res_next[NUM_DQ + i] = round_sat30(ext(mp[3 * i]) + ext(mp[3 * i + 1])
                                         + ext(mp[3 * i + 2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      dqp     <= dqp_next;
      qp      <= qp_next;
      vel1[0] <= vel_u;
      vel1[1] <= vel_v;
      vel1[2] <= vel_w;
    end
    if (en2 && v1) begin
      dq2  <= dq_next;
      rot2 <= rot_next;
      vel2 <= vel1;
    end
    if (en3 && v2) begin
      dq3 <= dq2;
      mp  <= mp_next;
    end
    if (en4 && v3) begin
      res4 <= res_next;
    end
  end

  assign out_valid = v4;
  assign dquat_w   = res4[0];
  assign dquat_x   = res4[1];
  assign dquat_y   = res4[2];
  assign dquat_z   = res4[3];
  assign dpos_x    = res4[4];
  assign dpos_y    = res4[5];
  assign dpos_z    = res4[6];

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !v1 && !v2 && !v3 && !v4)
    else $error("pipeline not empty after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted word missing from first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is full and stalled");

  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !en3 |=> v3 && $stable(mp[0]) && $stable(dq3[0]))
    else $error("stalled stage 3 word changed");
`endif

endmodule

// ----- hw/rtl/qrbk_rot_entries.sv -----
// qrbk_rot_entries: rotation matrix entries in Q2.30 from registered quaternion products
// depends on qrbk_pkg
module qrbk_rot_entries
  import qrbk_pkg::*;
(
  input  prod_t qp [NUM_Q_PROD],
  output word_t m  [NUM_ROT]
);

  acc_t e [NUM_ROT];

  always_comb begin
    e[0] = ONE_Q60 - dbl(qp[QP_YY]) - dbl(qp[QP_ZZ]);
    e[1] = dbl(qp[QP_XY]) - dbl(qp[QP_ZW]);
    e[2] = dbl(qp[QP_XZ]) + dbl(qp[QP_YW]);
    e[3] = dbl(qp[QP_XY]) + dbl(qp[QP_ZW]);
    e[4] = ONE_Q60 - dbl(qp[QP_XX]) - dbl(qp[QP_ZZ]);
    e[5] = dbl(qp[QP_YZ]) - dbl(qp[QP_XW]);
    e[6] = dbl(qp[QP_XZ]) - dbl(qp[QP_YW]);
    e[7] = dbl(qp[QP_YZ]) + dbl(qp[QP_XW]);
    e[8] = ONE_Q60 - dbl(qp[QP_XX]) - dbl(qp[QP_YY]);
    for (int i = 0; i < NUM_ROT; i++) begin
      m[i] = round_sat30(e[i]);
    end
  end

endmodule
